>>> sv/sitd_pkg.sv
`timescale 1ns / 1ps
// Shared widths, characters, structs and states for the decimal text block.
// No dependencies.
package sitd_pkg;

    localparam int VALUE_W = 32;
    localparam int CAP_W   = 16;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 4;
    localparam int BIT_CNT_W = 5;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [LEN_W-1:0]  NUM_DIGITS = 4'd10;

    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   mag;
    } sitd_conv_req_t;

    typedef struct packed {
        logic                 done;
        logic [BCD_W-1:0]     bcd;
    } sitd_conv_rsp_t;

    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [CAP_W-1:0]     cap;
        logic [BCD_W-1:0]     bcd;
    } sitd_emit_req_t;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_SKIP = 3'b010,
        E_SEND = 3'b100
    } sitd_emit_state_t;

endpackage

>>> sv/sitd_dabble.sv
`timescale 1ns / 1ps
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// Depends on sitd_pkg.
module sitd_dabble
    import sitd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  sitd_conv_req_t req,
    output sitd_conv_rsp_t rsp
);

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 running_reg, running_next;
    logic                 done_reg, done_next;
    logic [BCD_W-1:0]     adj;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            bin_next     = req.mag;
            bcd_next     = '0;
            cnt_next     = '0;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + BIT_CNT_W'(1);
            if (cnt_reg == '1)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign rsp.done = done_reg;
    assign rsp.bcd  = bcd_reg;

endmodule

>>> sv/sitd_emit.sv
`timescale 1ns / 1ps
// Leading-zero skip, length/fit check and character sequencer with output register.
// Depends on sitd_pkg.
module sitd_emit
    import sitd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sitd_emit_req_t    req,
    output logic              finished,
    output logic [CHAR_W-1:0] character,
    output logic              char_valid,
    output logic              fits,
    output logic [LEN_W-1:0]  text_length,
    output logic              last,
    output logic              out_valid,
    input  logic              out_ready
);

    sitd_emit_state_t   state_reg, state_next;
    logic [BCD_W-1:0]   dig_reg, dig_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               neg_reg, neg_next;
    logic               fit_reg, fit_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;

    logic               ov_reg, ov_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic               cv_reg, cv_next;
    logic               fo_reg, fo_next;
    logic [LEN_W-1:0]   lo_reg, lo_next;
    logic               last_reg, last_next;
    logic               fin_next;

    logic               slot_free;
    logic [LEN_W-1:0]   len_calc;

    assign slot_free = !ov_reg || out_ready;
    assign len_calc  = cnt_reg + {{(LEN_W-1){1'b0}}, neg_reg};

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        neg_next   = neg_reg;
        fit_next   = fit_reg;
        cap_next   = cap_reg;
        ov_next    = slot_free ? 1'b0 : ov_reg;
        ch_next    = ch_reg;
        cv_next    = cv_reg;
        fo_next    = fo_reg;
        lo_next    = lo_reg;
        last_next  = last_reg;
        fin_next   = 1'b0;
        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    dig_next   = req.bcd;
                    neg_next   = req.neg;
                    cap_next   = req.cap;
                    cnt_next   = NUM_DIGITS;
                    state_next = E_SKIP;
                end
            end
            E_SKIP:
            begin
                if (dig_reg[BCD_W-1 -: 4] == 4'd0 && cnt_reg > 4'd1)
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - LEN_W'(1);
                end
                else
                begin
                    len_next   = len_calc;
                    fit_next   = cap_reg >= {{(CAP_W-LEN_W){1'b0}}, len_calc};
                    state_next = E_SEND;
                end
            end
            E_SEND:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    fo_next = fit_reg;
                    lo_next = len_reg;
                    if (!fit_reg)
                    begin
                        ch_next    = '0;
                        cv_next    = 1'b0;
                        last_next  = 1'b1;
                        fin_next   = 1'b1;
                        state_next = E_IDLE;
                    end
                    else if (neg_reg)
                    begin
                        ch_next   = CHAR_MINUS;
                        cv_next   = 1'b1;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        ch_next   = CHAR_ZERO + {4'd0, dig_reg[BCD_W-1 -: 4]};
                        cv_next   = 1'b1;
                        dig_next  = {dig_reg[BCD_W-5:0], 4'd0};
                        cnt_next  = cnt_reg - LEN_W'(1);
                        last_next = (cnt_reg == 4'd1);
                        if (cnt_reg == 4'd1)
                        begin
                            fin_next   = 1'b1;
                            state_next = E_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            ov_reg    <= 1'b0;
            finished  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            finished  <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        cnt_reg  <= cnt_next;
        len_reg  <= len_next;
        neg_reg  <= neg_next;
        fit_reg  <= fit_next;
        cap_reg  <= cap_next;
        ch_reg   <= ch_next;
        cv_reg   <= cv_next;
        fo_reg   <= fo_next;
        lo_reg   <= lo_next;
        last_reg <= last_next;
    end

    assign out_valid   = ov_reg;
    assign character   = ch_reg;
    assign char_valid  = cv_reg;
    assign fits        = fo_reg;
    assign text_length = lo_reg;
    assign last        = last_reg;

endmodule

>>> sv/signed_int_to_decimal_text_core.sv
`timescale 1ns / 1ps
// Signed 32-bit integer to decimal ASCII text, top level.
// Depends on sitd_pkg, sitd_dabble, sitd_emit.
//
// Input channel (in_valid/in_ready): one word carries value and capacity.
// Output channel (out_valid/out_ready): one word per character, most
// significant first, '-' leading for negatives, last set on the final one.
// If the text is longer than capacity, a single word carries text_length
// with fits, char_valid and character clear and last set.
// Each word passes through serial shift-and-add-3 conversion, a handoff to
// the sequencer and the leading-zero skip; characters then follow one per
// cycle unless the receiver stalls the output register.
// One word is in work at a time: in_ready drops after acceptance and returns
// once the registered finished flag clears the busy register after the last
// output word is loaded, so the next word can be taken while that word still
// waits. With no output stalls the bit-serial converter, the leading-zero
// skip and the one-character-per-cycle output register set the input pace.
// A stalled receiver holds the output register; the sequencer waits.
// Reset clears all control state; no word is in flight afterward.
module signed_int_to_decimal_text_core
    import sitd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [CAP_W-1:0]         capacity,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CHAR_W-1:0]        character,
    output logic                     char_valid,
    output logic                     fits,
    output logic [LEN_W-1:0]         text_length,
    output logic                     last
);

    logic               busy_reg, busy_next;
    logic               neg_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic               accept;
    logic               finished;
    logic [VALUE_W-1:0] raw;

    sitd_conv_req_t conv_req;
    sitd_conv_rsp_t conv_rsp;
    sitd_emit_req_t emit_req;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign raw      = $unsigned(value);

    assign conv_req.start = accept;
    assign conv_req.mag   = raw[VALUE_W-1] ? ('0 - raw) : raw;

    assign emit_req.start = conv_rsp.done;
    assign emit_req.neg   = neg_reg;
    assign emit_req.cap   = cap_reg;
    assign emit_req.bcd   = conv_rsp.bcd;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (finished)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= raw[VALUE_W-1];
            cap_reg <= capacity;
        end
    end

    sitd_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .rsp   (conv_rsp)
    );

    sitd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (emit_req),
        .finished    (finished),
        .character   (character),
        .char_valid  (char_valid),
        .fits        (fits),
        .text_length (text_length),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

>>> sv/sitd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the decimal text block, bound to the top level.
// Depends on sitd_pkg and signed_int_to_decimal_text_core.
module sitd_checker
    import sitd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [CHAR_W-1:0]        character,
    input  logic                     char_valid,
    input  logic                     fits,
    input  logic [LEN_W-1:0]         text_length,
    input  logic                     last
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
        else $error("output word changed while stalled");

    // one word in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    a_nofit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fits |-> last && !char_valid && character == '0)
        else $error("no-fit word malformed");

    a_fit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fits |-> char_valid && text_length >= 4'd1 && text_length <= 4'd11)
        else $error("character word malformed");

endmodule

bind signed_int_to_decimal_text_core sitd_checker u_sitd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .character   (character),
    .char_valid  (char_valid),
    .fits        (fits),
    .text_length (text_length),
    .last        (last)
);
